// ----- design/tflh_pkg.sv -----
`timescale 1ns / 1ps

package tflh_pkg;

  localparam int TEMP_WIDTH_DEF = 16;

  localparam int THR_W    = 16;
  localparam int HYST_W   = 12;
  localparam int DUTY_W   = 7;
  localparam int LEVEL_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WARM_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_DUTY  = 3'd5;

  localparam logic signed [THR_W-1:0] WARM_THR_RST  = 16'sd640;
  localparam logic signed [THR_W-1:0] HOT_THR_RST   = 16'sd800;
  localparam logic [HYST_W-1:0]       HYST_RST      = 12'd80;
  localparam logic [DUTY_W-1:0]       BASE_DUTY_RST = 7'd30;
  localparam logic [DUTY_W-1:0]       WARM_DUTY_RST = 7'd70;
  localparam logic [DUTY_W-1:0]       HOT_DUTY_RST  = 7'd100;
  localparam logic [DUTY_W-1:0]       DUTY_MAX      = 7'd100;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_BASE = 2'd0,
    LVL_WARM = 2'd1,
    LVL_HOT  = 2'd2
  } tflh_level_t;

  typedef struct packed {
    logic signed [THR_W-1:0] warm_thr;
    logic signed [THR_W-1:0] hot_thr;
    logic [HYST_W-1:0]       hyst;
    logic [DUTY_W-1:0]       base_duty;
    logic [DUTY_W-1:0]       warm_duty;
    logic [DUTY_W-1:0]       hot_duty;
  } tflh_cfg_t;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
    sat_duty = (d > DUTY_MAX) ? DUTY_MAX : d;
  endfunction

endpackage

// ----- design/tflh_cfg_regs.sv -----
`timescale 1ns / 1ps

module tflh_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tflh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tflh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tflh_pkg::tflh_cfg_t               cfg
);
  import tflh_pkg::*;

  tflh_cfg_t cfg_r;
  tflh_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_WARM_THR:  cfg_nxt.warm_thr  = cfg_wdata[THR_W-1:0];
        REG_HOT_THR:   cfg_nxt.hot_thr   = cfg_wdata[THR_W-1:0];
        REG_HYST:      cfg_nxt.hyst      = cfg_wdata[HYST_W-1:0];
        REG_BASE_DUTY: cfg_nxt.base_duty = cfg_wdata[DUTY_W-1:0];
        REG_WARM_DUTY: cfg_nxt.warm_duty = cfg_wdata[DUTY_W-1:0];
        REG_HOT_DUTY:  cfg_nxt.hot_duty  = cfg_wdata[DUTY_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warm_thr  <= WARM_THR_RST;
      cfg_r.hot_thr   <= HOT_THR_RST;
      cfg_r.hyst      <= HYST_RST;
      cfg_r.base_duty <= BASE_DUTY_RST;
      cfg_r.warm_duty <= WARM_DUTY_RST;
      cfg_r.hot_duty  <= HOT_DUTY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/tflh_in_reg.sv -----
`timescale 1ns / 1ps

module tflh_in_reg #(
  parameter int TEMP_WIDTH = tflh_pkg::TEMP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [TEMP_WIDTH-1:0] in_temperature,
  input  logic                         in_last_of_scan,
  input  logic                         s1_go,
  output logic                         s1_valid,
  output logic signed [TEMP_WIDTH-1:0] s1_temp,
  output logic                         s1_last
);
  import tflh_pkg::*;

  logic                         valid_r;
  logic                         valid_nxt;
  logic signed [TEMP_WIDTH-1:0] temp_r;
  logic                         last_r;
  logic                         load;

  assign in_ready  = !valid_r || s1_go;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (s1_go ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      temp_r <= in_temperature;
      last_r <= in_last_of_scan;
    end
  end

  assign s1_valid = valid_r;
  assign s1_temp  = temp_r;
  assign s1_last  = last_r;

endmodule

// ----- design/tflh_update.sv -----
`timescale 1ns / 1ps

module tflh_update #(
  parameter int TEMP_WIDTH = tflh_pkg::TEMP_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tflh_pkg::tflh_cfg_t                  cfg,
  input  logic                                 s1_valid,
  input  logic signed [TEMP_WIDTH-1:0]         s1_temp,
  input  logic                                 s1_last,
  output logic                                 s1_go,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tflh_pkg::DUTY_W-1:0]          out_duty_percent,
  output logic [tflh_pkg::LEVEL_W-1:0]         out_fan_level,
  output logic signed [TEMP_WIDTH-1:0]         out_scan_maximum
);
  import tflh_pkg::*;

  localparam int CMP_W = ((TEMP_WIDTH > THR_W + 1) ? TEMP_WIDTH : THR_W + 1) + 1;
  localparam logic signed [TEMP_WIDTH-1:0] TEMP_MIN = {1'b1, {(TEMP_WIDTH-1){1'b0}}};

  logic signed [TEMP_WIDTH-1:0] max_r;
  logic signed [TEMP_WIDTH-1:0] max_nxt;
  tflh_level_t                  level_r;
  tflh_level_t                  level_nxt;
  tflh_level_t                  level_new;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [DUTY_W-1:0]            duty_r;
  logic [DUTY_W-1:0]            duty_sel;
  tflh_level_t                  out_level_r;
  logic signed [TEMP_WIDTH-1:0] out_max_r;

  logic signed [TEMP_WIDTH-1:0] max_upd;
  logic signed [CMP_W-1:0]      t_ext;
  logic signed [CMP_W-1:0]      max_ext;
  logic signed [CMP_W-1:0]      m_ext;
  logic signed [CMP_W-1:0]      warm_ext;
  logic signed [CMP_W-1:0]      hot_ext;
  logic signed [CMP_W-1:0]      hyst_ext;
  logic signed [CMP_W-1:0]      warm_low;
  logic signed [CMP_W-1:0]      hot_low;
  logic                         out_free;
  logic                         out_load;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign out_load = s1_go && s1_last;

  always_comb begin
    t_ext    = {{(CMP_W-TEMP_WIDTH){s1_temp[TEMP_WIDTH-1]}}, s1_temp};
    max_ext  = {{(CMP_W-TEMP_WIDTH){max_r[TEMP_WIDTH-1]}}, max_r};
    max_upd  = (t_ext > max_ext) ? s1_temp : max_r;
    m_ext    = {{(CMP_W-TEMP_WIDTH){max_upd[TEMP_WIDTH-1]}}, max_upd};
    warm_ext = {{(CMP_W-THR_W){cfg.warm_thr[THR_W-1]}}, cfg.warm_thr};
    hot_ext  = {{(CMP_W-THR_W){cfg.hot_thr[THR_W-1]}}, cfg.hot_thr};
    hyst_ext = {{(CMP_W-HYST_W){1'b0}}, cfg.hyst};
    warm_low = warm_ext - hyst_ext;
    hot_low  = hot_ext - hyst_ext;

    level_new = level_r;
    duty_sel  = cfg.base_duty;
    case (level_r)
      LVL_BASE: begin
        duty_sel = cfg.base_duty;
        if (m_ext > warm_ext) level_new = LVL_WARM;
      end
      LVL_WARM: begin
        duty_sel = cfg.warm_duty;
        if (m_ext > hot_ext) begin
          level_new = LVL_HOT;
        end else if (m_ext < warm_low) begin
          level_new = LVL_BASE;
        end
      end
      LVL_HOT: begin
        duty_sel = cfg.hot_duty;
        if (m_ext < hot_low) level_new = LVL_WARM;
      end
      default: begin
        duty_sel  = cfg.base_duty;
        level_new = LVL_BASE;
      end
    endcase

    max_nxt       = max_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_go) begin
      if (s1_last) begin
        max_nxt       = TEMP_MIN;
        level_nxt     = level_new;
        out_valid_nxt = 1'b1;
      end else begin
        max_nxt = max_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= TEMP_MIN;
      level_r     <= LVL_BASE;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty_r      <= sat_duty(duty_sel);
      out_level_r <= level_new;
      out_max_r   <= max_upd;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty_percent = duty_r;
  assign out_fan_level    = out_level_r;
  assign out_scan_maximum = out_max_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("closing transfer did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before its transfer");

  a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (max_r == TEMP_MIN))
    else $error("running maximum not cleared at end of scan");

  a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_last) |=> $stable(level_r))
    else $error("fan level changed in the middle of a scan");

endmodule

// ----- design/thermal_fan_level_hysteresis_top.sv -----
`timescale 1ns / 1ps

// Three-level fan controller with hysteresis. Temperatures are transferred one per cycle; each
// is registered, folded into the running scan maximum in the following cycle, and on the item
// marked last of scan a result (duty of the previous level, new level, scan maximum) passes from
// the input register into the output register. Non-final items produce no result.
// The sustained rate is one item per clock, with a single maximum compare and level update
// between the input register and the output register; the block stalls input only when a final
// item meets a result that has not yet been taken.
module thermal_fan_level_hysteresis_top #(
  parameter int TEMP_WIDTH = tflh_pkg::TEMP_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [TEMP_WIDTH-1:0]       in_temperature,
  input  logic                               in_last_of_scan,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tflh_pkg::DUTY_W-1:0]        out_duty_percent,
  output logic [tflh_pkg::LEVEL_W-1:0]       out_fan_level,
  output logic signed [TEMP_WIDTH-1:0]       out_scan_maximum,
  input  logic                               cfg_wr_en,
  input  logic [tflh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tflh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tflh_pkg::*;

  tflh_cfg_t                    cfg;
  logic                         s1_go;
  logic                         s1_valid;
  logic signed [TEMP_WIDTH-1:0] s1_temp;
  logic                         s1_last;

  tflh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tflh_in_reg #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_temperature  (in_temperature),
    .in_last_of_scan (in_last_of_scan),
    .s1_go           (s1_go),
    .s1_valid        (s1_valid),
    .s1_temp         (s1_temp),
    .s1_last         (s1_last)
  );

  tflh_update #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_upd (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .s1_valid         (s1_valid),
    .s1_temp          (s1_temp),
    .s1_last          (s1_last),
    .s1_go            (s1_go),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_duty_percent (out_duty_percent),
    .out_fan_level    (out_fan_level),
    .out_scan_maximum (out_scan_maximum)
  );

endmodule
